// ===== sv/dcs_pkg.sv =====
// shared constants and types of the display capacity smoother
`timescale 1ns / 1ps
package dcs_pkg;

  localparam int unsigned AmountW = 32;
  localparam int unsigned SocW    = 17;
  localparam int unsigned FacW    = 15;
  localparam int unsigned CfgW    = 14;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DirW    = 2;
  localparam int unsigned FullW   = 33;
  localparam int unsigned BfW     = 47;
  localparam int unsigned DenW    = 46;
  localparam int unsigned RemW    = 47;
  localparam int unsigned MulAW   = 33;
  localparam int unsigned MulBW   = 17;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned CntW    = 5;
  localparam int unsigned FnumW   = 23;

  localparam logic [CfgIdxW-1:0] CfgBaseChg  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBaseDis  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCapacity = 2'd2;

  localparam logic [CfgW-1:0]    CapReset   = 14'd100;
  localparam logic [MulAW-1:0]   AmsPerCap  = 33'd360000;
  localparam logic [MulBW-1:0]   SocScale   = 17'd10000;
  localparam logic [SocW-1:0]    SocOne     = 17'd65536;
  localparam logic [SocW-1:0]    SocQuarter = 17'd16384;
  localparam logic [FacW-1:0]    FacMax     = 15'd24576;
  localparam logic [FacW-1:0]    FacMin     = 15'd10923;
  localparam logic [CntW-1:0]    SocSteps   = 5'd17;
  localparam logic [CntW-1:0]    FacSteps   = 5'd15;
  localparam logic [20:0]        SnapLimit  = 21'd196608;  // 0.3 of one, times 10
  localparam logic [21:0]        EndNear20  = 22'd1245184; // 0.95 of one, times 20
  localparam logic [21:0]        EndFull20  = 22'd1310720;
  localparam logic [DirW-1:0]    DirAdd     = 2'b01;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FULL,
    ST_BASE,
    ST_CNT,
    ST_DEN,
    ST_CLAMP,
    ST_DIV,
    ST_POST,
    ST_DISP,
    ST_CMP,
    ST_FAC,
    ST_SNAP,
    ST_APPLY,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_COUNTED,
    PH_DISPLAY,
    PH_FACTOR
  } phase_e;

endpackage

// ===== sv/dcs_if.sv =====
// channel interfaces of the display capacity smoother
`timescale 1ns / 1ps
interface dcs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] amount;
  logic signed [1:0] direction;
  logic        charging;
  logic [31:0] counted_charge;
  logic        counted_positive;

  modport source (output valid, command, amount, direction, charging, counted_charge,
                  counted_positive, input ready);
  modport sink (input valid, command, amount, direction, charging, counted_charge,
                counted_positive, output ready);
  modport monitor (input valid, ready, command, amount, direction, charging, counted_charge,
                   counted_positive);
endinterface

interface dcs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] display_charge;
  logic [31:0] applied_increment;
  logic [16:0] counted_soc;
  logic        snapped;

  modport source (output valid, display_charge, applied_increment, counted_soc, snapped,
                  input ready);
  modport sink (input valid, display_charge, applied_increment, counted_soc, snapped,
                output ready);
  modport monitor (input valid, ready, display_charge, applied_increment, counted_soc,
                   snapped);
endinterface

interface dcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

// ===== sv/display_capacity_soc_smoother.sv =====
// top level of the display capacity smoother
`timescale 1ns / 1ps
// Keeps the displayed remaining charge of a battery pack. Each transaction on in_i yields
// exactly one transaction on out_o. The work runs on one multiplier and one restoring
// divider (one quotient bit per cycle) under a sequencer; an accumulate takes longer than
// a load, depending on whether the display SOC and the factor need a division. Each SOC
// division runs 17 steps. The block takes no new item until the last result is taken.
// in_i is ready only while the block is idle; a result stays on out_o until taken.
// Configuration writes on cfg_i are always accepted and must arrive while idle.
module display_capacity_soc_smoother
  import dcs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  dcs_cfg_if.sink   cfg_i,
  dcs_in_if.sink    in_i,
  dcs_out_if.source out_o
);

  state_e state_q, state_d;
  phase_e phase_q;

  logic [CfgW-1:0] base_chg_q, base_dis_q, cap_q;
  logic [AmountW-1:0] cur_q;

  logic               cmd_q, chg_q, gain_q;
  logic [AmountW-1:0] amount_q, cnt_in_q;
  logic [DirW-1:0]    dir_q;

  logic [FullW-1:0] full_q;
  logic [BfW-1:0]   bf_q;
  logic [DenW-1:0]  cd_q, den_q, dv_q;
  logic [RemW-1:0]  r_q;
  logic [SocW-1:0]  q_q, s_q, dsoc_q;
  logic [CntW-1:0]  cnt_q;
  logic             first_q, snap_q;
  logic signed [FnumW-1:0] fnum_q, fden_q;
  logic [FacW-1:0]  fac_q;

  logic               out_valid_q;
  logic [AmountW-1:0] out_disp_q, out_appl_q;
  logic [SocW-1:0]    out_soc_q;
  logic               out_snap_q;

  logic in_acc, out_acc;

  // shared multiplier
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [CfgW-1:0]  cap_eff;

  always_comb begin
    cap_eff = (cap_q == '0) ? CfgW'(1) : cap_q;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      ST_FULL: begin
        mul_a = AmsPerCap;
        mul_b = {3'b0, cap_eff};
      end
      ST_BASE: begin
        mul_a = full_q;
        mul_b = {3'b0, (chg_q ? base_chg_q : base_dis_q)};
      end
      ST_CNT: begin
        mul_a = {1'b0, cnt_in_q};
        mul_b = SocScale;
      end
      ST_DEN: begin
        mul_a = full_q;
        mul_b = SocScale;
      end
      ST_SNAP: begin
        mul_a = full_q;
        mul_b = s_q;
      end
      ST_APPLY: begin
        mul_a = {1'b0, amount_q};
        mul_b = {2'b0, fac_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};
  end

  // divider step and other datapath helpers
  logic [RemW-1:0] rs;
  logic            ge;
  logic signed [BfW+1:0] numw;
  logic [RemW-1:0] num_clamped;
  logic [SocW-1:0] diff;
  logic [20:0]     diff10;
  logic [21:0]     d20, s20, end20;
  logic [SocW-1:0] end_dis;
  logic signed [FnumW-1:0] fnum_d, fden_d, nneg, dneg;
  logic [21:0]     an, ad;
  logic [FacW-1:0] fac_clamped;
  logic [33:0]     snap_v;
  logic [AmountW-1:0] snap_next;
  logic [32:0]     appl_w;
  logic [AmountW-1:0] appl, apply_next, head;

  always_comb begin
    rs = first_q ? r_q : {r_q[RemW-2:0], 1'b0};
    ge = (rs >= {1'b0, dv_q});

    numw = gain_q ? ($signed({2'b0, bf_q}) + $signed({3'b0, cd_q}))
                  : ($signed({2'b0, bf_q}) - $signed({3'b0, cd_q}));
    if (numw[BfW+1]) num_clamped = '0;
    else if (numw[BfW:0] > {2'b0, den_q}) num_clamped = {1'b0, den_q};
    else num_clamped = numw[RemW-1:0];

    diff   = (dsoc_q > s_q) ? (dsoc_q - s_q) : (s_q - dsoc_q);
    diff10 = 21'(diff) * 21'd10;

    d20   = 22'(dsoc_q) * 22'd20;
    s20   = 22'(s_q) * 22'd20;
    end20 = ((d20 > EndNear20) || (s20 > EndNear20)) ? EndFull20 : EndNear20;
    end_dis = ((dsoc_q < SocQuarter) || (s_q < SocQuarter)) ? '0 : SocQuarter;
    if (chg_q) begin
      fnum_d = $signed({1'b0, end20}) - $signed({1'b0, d20});
      fden_d = $signed({1'b0, end20}) - $signed({1'b0, s20});
    end else begin
      fnum_d = $signed({6'b0, dsoc_q}) - $signed({6'b0, end_dis});
      fden_d = $signed({6'b0, s_q}) - $signed({6'b0, end_dis});
    end

    nneg = -fnum_q;
    dneg = -fden_q;
    an = fnum_q[FnumW-1] ? nneg[21:0] : fnum_q[21:0];
    ad = fden_q[FnumW-1] ? dneg[21:0] : fden_q[21:0];

    if (q_q > {2'b0, FacMax}) fac_clamped = FacMax;
    else if (q_q < {2'b0, FacMin}) fac_clamped = FacMin;
    else fac_clamped = q_q[FacW-1:0];

    snap_v    = prod[ProdW-1:16];
    snap_next = (snap_v[33:32] != 2'b0) ? '1 : snap_v[31:0];

    appl_w = prod[46:14];
    appl   = appl_w[32] ? '1 : appl_w[31:0];
    head   = ~cur_q;
    if (dir_q == DirAdd) apply_next = (head < appl) ? '1 : (cur_q + appl);
    else if (dir_q[1]) apply_next = (cur_q > appl) ? (cur_q - appl) : '0;
    else apply_next = cur_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_FULL;
      ST_FULL:  state_d = ST_BASE;
      ST_BASE:  state_d = ST_CNT;
      ST_CNT:   state_d = ST_DEN;
      ST_DEN:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CntW'(1)) state_d = ST_POST;
      ST_POST: begin
        case (phase_q)
          PH_COUNTED: state_d = cmd_q ? ST_OUT : ST_DISP;
          PH_DISPLAY: state_d = ST_CMP;
          default:    state_d = ST_APPLY;
        endcase
      end
      ST_DISP:  state_d = (cur_q >= full_q[AmountW-1:0] && full_q[FullW-1] == 1'b0)
                          ? ST_CMP : ST_DIV;
      ST_CMP:   state_d = (diff10 > SnapLimit) ? ST_SNAP : ST_FAC;
      ST_FAC: begin
        if (fden_q == '0 || fnum_q == '0 || (fnum_q[FnumW-1] != fden_q[FnumW-1])
            || ({1'b0, an} >= {ad, 1'b0}))
          state_d = ST_APPLY;
        else
          state_d = ST_DIV;
      end
      ST_SNAP:  state_d = ST_OUT;
      ST_APPLY: state_d = ST_OUT;
      ST_OUT:   if (out_acc) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    cfg_i.ready = 1'b1;
    out_o.valid = out_valid_q;
    out_o.display_charge    = out_disp_q;
    out_o.applied_increment = out_appl_q;
    out_o.counted_soc       = out_soc_q;
    out_o.snapped           = out_snap_q;
  end

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // control state, configuration and display charge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_COUNTED;
      cnt_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      base_chg_q  <= '0;
      base_dis_q  <= '0;
      cap_q       <= CapReset;
      cur_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CfgBaseChg) base_chg_q <= cfg_i.data;
        else if (cfg_i.index == CfgBaseDis) base_dis_q <= cfg_i.data;
        else if (cfg_i.index == CfgCapacity) cap_q <= cfg_i.data;
      end
      case (state_q)
        ST_CLAMP: begin
          cnt_q   <= SocSteps;
          first_q <= 1'b1;
          phase_q <= PH_COUNTED;
        end
        ST_DIV: begin
          cnt_q   <= cnt_q - CntW'(1);
          first_q <= 1'b0;
        end
        ST_POST: begin
          if (phase_q == PH_COUNTED && cmd_q) begin
            cur_q       <= amount_q;
            out_valid_q <= 1'b1;
          end
        end
        ST_DISP: begin
          cnt_q   <= SocSteps;
          first_q <= 1'b1;
          phase_q <= PH_DISPLAY;
        end
        ST_FAC: begin
          cnt_q   <= FacSteps;
          first_q <= 1'b1;
          phase_q <= PH_FACTOR;
        end
        ST_SNAP: begin
          cur_q       <= snap_next;
          out_valid_q <= 1'b1;
        end
        ST_APPLY: begin
          cur_q       <= apply_next;
          out_valid_q <= 1'b1;
        end
        ST_OUT: begin
          if (out_acc) out_valid_q <= 1'b0;
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_q    <= in_i.command;
          amount_q <= in_i.amount;
          dir_q    <= in_i.direction;
          chg_q    <= in_i.charging;
          cnt_in_q <= in_i.counted_charge;
          gain_q   <= in_i.counted_positive;
        end
      end
      ST_FULL:  full_q <= prod[FullW-1:0];
      ST_BASE:  bf_q   <= prod[BfW-1:0];
      ST_CNT:   cd_q   <= prod[DenW-1:0];
      ST_DEN:   den_q  <= prod[DenW-1:0];
      ST_CLAMP: begin
        r_q  <= num_clamped;
        dv_q <= den_q;
        q_q  <= '0;
      end
      ST_DIV: begin
        r_q <= ge ? (rs - {1'b0, dv_q}) : rs;
        q_q <= {q_q[SocW-2:0], ge};
      end
      ST_POST: begin
        case (phase_q)
          PH_COUNTED: begin
            s_q <= q_q;
            out_disp_q <= amount_q;
            out_appl_q <= '0;
            out_soc_q  <= q_q;
            out_snap_q <= 1'b0;
          end
          PH_DISPLAY: dsoc_q <= q_q;
          default:    fac_q  <= fac_clamped;
        endcase
      end
      ST_DISP: begin
        dsoc_q <= SocOne;
        r_q    <= {{(RemW-AmountW){1'b0}}, cur_q};
        dv_q   <= {{(DenW-FullW){1'b0}}, full_q};
        q_q    <= '0;
      end
      ST_CMP: begin
        snap_q <= (diff10 > SnapLimit);
        fnum_q <= fnum_d;
        fden_q <= fden_d;
      end
      ST_FAC: begin
        if (fden_q == '0) fac_q <= FacMax;
        else if (fnum_q == '0 || (fnum_q[FnumW-1] != fden_q[FnumW-1])) fac_q <= FacMin;
        else fac_q <= FacMax;
        r_q  <= {{(RemW-22){1'b0}}, an};
        dv_q <= {{(DenW-22){1'b0}}, ad};
        q_q  <= '0;
      end
      ST_SNAP: begin
        out_disp_q <= snap_next;
        out_appl_q <= '0;
        out_soc_q  <= s_q;
        out_snap_q <= 1'b1;
      end
      ST_APPLY: begin
        out_disp_q <= apply_next;
        out_appl_q <= appl;
        out_soc_q  <= s_q;
        out_snap_q <= snap_q;
      end
      default: begin
        fac_q <= fac_q;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_snap_no_incr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.snapped |-> out_o.applied_increment == '0)
    else $error("snapped result carries an increment");

  a_soc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.counted_soc <= SocOne)
    else $error("counted soc above one");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready && !out_o.valid)
    else $error("block not busy after accepting a transaction");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready |=> in_i.ready && !out_o.valid)
    else $error("block not idle after result taken");
`endif

endmodule
